@@ src/matrix_multiply_transposed_defines.svh @@
// assertion macros for the matrix multiply transposed block
`ifndef MATRIX_MULTIPLY_TRANSPOSED_DEFINES_SVH
`define MATRIX_MULTIPLY_TRANSPOSED_DEFINES_SVH

`ifndef SYNTHESIS
`define MMT_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MMT_ASSERT_IMPLY(lbl, ante, cons, msg)
`define MMT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ src/mmt_pkg.sv @@
// shared types and constants for the matrix multiply transposed block
`default_nettype none

package mmt_pkg;

  localparam int DEF_LEFT_ROWS  = 64;
  localparam int DEF_RIGHT_ROWS = 64;
  localparam int DEF_MAX_DEPTH  = 64;

  localparam int IDX_W    = 6;
  localparam int ELEM_W   = 16;
  localparam int PROD_W   = 2 * ELEM_W;
  localparam int DOT_W    = 38;
  localparam int OIDX_W   = 18;
  localparam int DEPTH_W  = 7;
  localparam int STRIDE_W = 13;
  localparam int CFG_W    = 13;

  localparam logic [DEPTH_W-1:0]  DEPTH_RESET  = 7'd64;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd64;

  localparam logic CFG_DEPTH  = 1'b0;
  localparam logic CFG_STRIDE = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic clear;
    logic data_valid;
  } mac_ctrl_t;

endpackage

`default_nettype wire

@@ src/mmt_mac.sv @@
// multiply-accumulate unit with a registered product stage
`default_nettype none

module mmt_mac import mmt_pkg::*; (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire  mac_ctrl_t          ctrl,
  input  wire  signed [ELEM_W-1:0] a,
  input  wire  signed [ELEM_W-1:0] b,
  output logic signed [DOT_W-1:0]  acc,
  output logic                     busy
);

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_v_r;
  logic signed [DOT_W-1:0]  acc_r;
  logic signed [DOT_W-1:0]  acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctrl.data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.data_valid) begin
      prod_r <= PROD_W'(a) * PROD_W'(b);
    end
  end

  // 38-bit sum wraps like the low bits of the exact sum
  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (prod_v_r) begin
      acc_nxt = acc_r + DOT_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc  = acc_r;
  assign busy = prod_v_r;

endmodule

`default_nettype wire

@@ src/matrix_multiply_transposed.sv @@
// top level: element stores, query sequencer and output strobe
//
// Loads (op 0 and 1) do not raise busy and give no result. A query (op 2)
// keeps busy high while the sequencer walks min(depth_in_use, MAX_DEPTH)
// element pairs and drains the read and product stages; a row out of range
// or a depth of zero skips the walk. out_valid then pulses for one cycle,
// the first cycle with busy low again. The walk is carried by the one
// multiply-accumulate unit and the single read port of each element store,
// which take one element pair per cycle. The result fields stay stable until the next query is accepted, but
// the receiver cannot stall: it must take the transfer in the strobe cycle.
// Configuration must be written only while busy is low and no strobe is due.
`default_nettype none
`include "matrix_multiply_transposed_defines.svh"

module matrix_multiply_transposed import mmt_pkg::*; #(
  parameter int LEFT_ROWS  = DEF_LEFT_ROWS,
  parameter int RIGHT_ROWS = DEF_RIGHT_ROWS,
  parameter int MAX_DEPTH  = DEF_MAX_DEPTH
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  output logic                     busy,
  input  wire  [1:0]               in_op,
  input  wire  [IDX_W-1:0]         in_first_index,
  input  wire  [IDX_W-1:0]         in_second_index,
  input  wire  signed [ELEM_W-1:0] in_element_value,
  output logic                     out_valid,
  output logic [IDX_W-1:0]         out_result_row,
  output logic [IDX_W-1:0]         out_result_col,
  output logic [OIDX_W-1:0]        out_result_index,
  output logic signed [DOT_W-1:0]  out_dot_value,
  input  wire                      cfg_we,
  input  wire                      cfg_index,
  input  wire  [CFG_W-1:0]         cfg_wdata
);

  localparam int L_ENTRIES = LEFT_ROWS * MAX_DEPTH;
  localparam int R_ENTRIES = RIGHT_ROWS * MAX_DEPTH;
  localparam int AW_L      = (L_ENTRIES > 1) ? $clog2(L_ENTRIES) : 1;
  localparam int AW_R      = (R_ENTRIES > 1) ? $clog2(R_ENTRIES) : 1;
  localparam int CW        = $clog2(MAX_DEPTH + 1);

  state_t                   state_r;
  state_t                   state_nxt;
  logic [DEPTH_W-1:0]       depth_r;
  logic [STRIDE_W-1:0]      stride_r;
  logic [CW-1:0]            k_r;
  logic [CW-1:0]            k_nxt;
  logic [CW-1:0]            eff_r;
  logic [CW-1:0]            eff_in;
  logic [IDX_W-1:0]         row_a_r;
  logic [IDX_W-1:0]         row_b_r;
  logic [OIDX_W-1:0]        idx_r;
  logic                     rd_v_r;
  logic signed [ELEM_W-1:0] rd_a_r;
  logic signed [ELEM_W-1:0] rd_b_r;
  logic                     out_valid_r;

  logic [ELEM_W-1:0] left_mem  [L_ENTRIES];
  logic [ELEM_W-1:0] right_mem [R_ENTRIES];

  op_t               op;
  logic              accept;
  logic              is_query;
  logic              we_a;
  logic              we_b;
  logic              rows_ok;
  logic              issue;
  logic              fire;
  logic              pipe_empty;
  logic [AW_L-1:0]   waddr_a;
  logic [AW_R-1:0]   waddr_b;
  logic [AW_L-1:0]   raddr_a;
  logic [AW_R-1:0]   raddr_b;
  mac_ctrl_t         mac_ctrl;
  logic signed [DOT_W-1:0] mac_acc;
  logic              mac_busy;

  assign op       = op_t'(in_op);
  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign is_query = accept && (op == OP_QUERY);

  assign we_a = accept && (op == OP_LOAD_A) && (32'(in_first_index) < LEFT_ROWS)
                && (32'(in_second_index) < MAX_DEPTH);
  assign we_b = accept && (op == OP_LOAD_B) && (32'(in_first_index) < RIGHT_ROWS)
                && (32'(in_second_index) < MAX_DEPTH);
  assign waddr_a = AW_L'(32'(in_first_index) * MAX_DEPTH + 32'(in_second_index));
  assign waddr_b = AW_R'(32'(in_first_index) * MAX_DEPTH + 32'(in_second_index));
  assign raddr_a = AW_L'(32'(row_a_r) * MAX_DEPTH + 32'(k_r));
  assign raddr_b = AW_R'(32'(row_b_r) * MAX_DEPTH + 32'(k_r));

  // rows outside the stores contribute nothing, so the walk is skipped
  assign rows_ok = (32'(in_first_index) < LEFT_ROWS) && (32'(in_second_index) < RIGHT_ROWS);

  always_comb begin
    if (!rows_ok) begin
      eff_in = '0;
    end else if (32'(depth_r) > MAX_DEPTH) begin
      eff_in = CW'(MAX_DEPTH);
    end else begin
      eff_in = CW'(depth_r);
    end
  end

  assign pipe_empty = !rd_v_r && !mac_busy;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (is_query) begin
          state_nxt = (eff_in == '0) ? ST_DRAIN : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (k_r == eff_r - CW'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    issue = 1'b0;
    fire  = 1'b0;
    k_nxt = '0;
    case (state_r)
      ST_IDLE: begin
        k_nxt = '0;
      end
      ST_ISSUE: begin
        issue = 1'b1;
        k_nxt = k_r + CW'(1);
      end
      ST_DRAIN: begin
        fire = pipe_empty;
      end
      default: begin
        k_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      depth_r     <= DEPTH_RESET;
      stride_r    <= STRIDE_RESET;
      k_r         <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      rd_v_r      <= issue;
      out_valid_r <= fire;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEPTH:  depth_r  <= cfg_wdata[DEPTH_W-1:0];
          CFG_STRIDE: stride_r <= cfg_wdata[STRIDE_W-1:0];
          default:    depth_r  <= depth_r;
        endcase
      end
    end
  end

  // query operands held for the whole walk and for the result transfer
  always_ff @(posedge clk) begin
    if (is_query) begin
      row_a_r <= in_first_index;
      row_b_r <= in_second_index;
      eff_r   <= eff_in;
      idx_r   <= OIDX_W'(32'(in_first_index) * 32'(stride_r) + 32'(in_second_index));
    end
  end

  always_ff @(posedge clk) begin
    if (we_a) begin
      left_mem[waddr_a] <= in_element_value;
    end
    if (issue) begin
      rd_a_r <= left_mem[raddr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      right_mem[waddr_b] <= in_element_value;
    end
    if (issue) begin
      rd_b_r <= right_mem[raddr_b];
    end
  end

  assign mac_ctrl.clear      = is_query;
  assign mac_ctrl.data_valid = rd_v_r;

  mmt_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .a     (rd_a_r),
    .b     (rd_b_r),
    .acc   (mac_acc),
    .busy  (mac_busy)
  );

  assign out_valid        = out_valid_r;
  assign out_result_row   = row_a_r;
  assign out_result_col   = row_b_r;
  assign out_result_index = idx_r;
  assign out_dot_value    = mac_acc;

  `MMT_ASSERT_IMPLY(a_strobe_when_idle, out_valid_r, state_r == ST_IDLE, "strobe while busy")
  `MMT_ASSERT_NEXT(a_strobe_single, out_valid_r, !out_valid_r, "strobe longer than one cycle")
  `MMT_ASSERT_NEXT(a_query_goes_busy, is_query, busy, "query accepted but not busy")
  `MMT_ASSERT_IMPLY(a_idle_pipe_empty, state_r == ST_IDLE, pipe_empty, "mac pipe active in idle")
  `MMT_ASSERT_IMPLY(a_walk_in_range, state_r == ST_ISSUE, k_r < eff_r, "element walk past depth")

endmodule

`default_nettype wire
